// File: design/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared widths, register map, configuration and window types of the 3x3
// Sobel gradient block.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int unsigned PIX_W    = 10;
  localparam int unsigned MAX_COLS = 1024;
  localparam int unsigned MAX_ROWS = 1024;
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned GRAD_W   = 13;
  localparam int unsigned MAG_W    = 25;
  localparam int unsigned SQ_W     = MAG_W - 1;
  localparam int unsigned MEM_W    = 2 * PIX_W;

  localparam logic [SIZE_W-1:0] MIN_SIZE    = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] COLS_LIMIT  = SIZE_W'(MAX_COLS);
  localparam logic [SIZE_W-1:0] ROWS_LIMIT  = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] COLS_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] ROWS_RESET  = SIZE_W'(480);

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS = REG_IDX_W'(1);

  typedef struct packed {
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
  } frame_size_t;

  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    window_t          window;
    logic             interior;
    logic [ROW_W-1:0] centre_row;
    logic [COL_W-1:0] centre_col;
  } win_item_t;

  function automatic logic signed [GRAD_W-1:0] pix_ext(input logic [PIX_W-1:0] p);
    pix_ext = signed'(GRAD_W'(p));
  endfunction

endpackage

// File: design/sobel_gradient_3x3.sv
// ----------------------------------------------------------------------------
// sobel_gradient_3x3
// Streaming 3x3 Sobel gradient with squared magnitude.
//
// Pixels enter in raster order on the input channel, one beat per pixel; the
// beat that carries frame_start is taken as row 0, column 0. Each pixel at
// row r and column c, both at least 1, gives one result beat for the centre
// (r-1, c-1); other pixels give none. Centres on row 0 or column 0 carry zero
// gradients. Frame size is set through the APB-style register port; the user
// is to set it only while the block is idle, which the block itself does not
// enforce. Out-of-range sizes are held to 3..1024. One pixel is taken every
// cycle while the output does not stall; the line memory, with one read and
// one write port, sets this rate: it is read when a pixel is taken, written
// back as the pixel leaves the first stage, with forwarding for neighbouring
// beats. When the receiver stalls, results queue in the pipeline registers
// and the input keeps taking beats until every stage behind the line memory
// is full. After reset the frame size is 640 by 480, the position is row 0,
// column 0, the window is zero and the line memory holds nothing defined.
// ----------------------------------------------------------------------------
module sobel_gradient_3x3 import sobel_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [PIX_W-1:0]         pixel_i,
  input  logic                     frame_start_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic signed [GRAD_W-1:0] grad_x_o,
  output logic signed [GRAD_W-1:0] grad_y_o,
  output logic [MAG_W-1:0]         grad_mag_sq_o,
  output logic [ROW_W-1:0]         centre_row_o,
  output logic [COL_W-1:0]         centre_col_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready
);

  frame_size_t size;
  win_item_t   item;
  logic        item_valid, item_ready;

  sobel_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_o  (size)
  );

  sobel_line_mem u_line (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .size_i        (size),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready)
  );

  sobel_grad_pipe u_grad (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .grad_x_o      (grad_x_o),
    .grad_y_o      (grad_y_o),
    .grad_mag_sq_o (grad_mag_sq_o),
    .centre_row_o  (centre_row_o),
    .centre_col_o  (centre_col_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

// File: design/sobel_cfg_regs.sv
// ----------------------------------------------------------------------------
// sobel_cfg_regs
// Register file for the frame size, with a simple APB-style port. The values
// in use are held to their legal ranges.
// ----------------------------------------------------------------------------
module sobel_cfg_regs import sobel_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output frame_size_t           size_o
);

  logic [SIZE_W-1:0]    cols_q, rows_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_COLS: cols_q <= pwdata[SIZE_W-1:0];
        REG_FRAME_ROWS: rows_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_COLS: prdata = APB_DATA_W'(cols_q);
      REG_FRAME_ROWS: prdata = APB_DATA_W'(rows_q);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    size_o.cols = (cols_q < MIN_SIZE) ? MIN_SIZE :
                  (cols_q > COLS_LIMIT) ? COLS_LIMIT : cols_q;
    size_o.rows = (rows_q < MIN_SIZE) ? MIN_SIZE :
                  (rows_q > ROWS_LIMIT) ? ROWS_LIMIT : rows_q;
  end

endmodule

// File: design/sobel_line_mem.sv
// ----------------------------------------------------------------------------
// sobel_line_mem
// Raster position tracking, the two line stores in one synchronous memory and
// the 3x3 window. Each pixel reads its column, shifts the window and writes
// the column back as it leaves the first stage, with forwarding for a
// back-to-back access to the same column.
// ----------------------------------------------------------------------------
module sobel_line_mem import sobel_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  frame_size_t      size_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             frame_start_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output win_item_t        item_o,
  output logic             item_valid_o,
  input  logic             item_ready_i
);

  logic [MEM_W-1:0] line_mem [MAX_COLS];

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;

  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [MEM_W-1:0] rd_q;
  logic             fwd_q;
  logic [MEM_W-1:0] fwd_data_q;

  logic [PIX_W-1:0] up1, up2;
  logic             s1_adv, s1_emit, accept;

  window_t          win_q;
  logic             s2_valid_q;
  logic             s2_interior_q;
  logic [ROW_W-1:0] s2_row_q;
  logic [COL_W-1:0] s2_col_q;

  always_comb begin
    logic [SIZE_W-1:0] c_t, r_t, c_n, r_n;
    c_t = frame_start_i ? '0 : SIZE_W'(col_q);
    r_t = frame_start_i ? '0 : SIZE_W'(row_q);
    if (c_t >= size_i.cols) begin
      c_t = '0;
      r_t = r_t + 1'b1;
    end
    if (r_t >= size_i.rows) begin
      r_t = '0;
    end
    c_n = c_t + 1'b1;
    r_n = r_t;
    if (c_n >= size_i.cols) begin
      c_n = '0;
      r_n = r_t + 1'b1;
      if (r_n >= size_i.rows) begin
        r_n = '0;
      end
    end
    cur_col = c_t[COL_W-1:0];
    cur_row = r_t[ROW_W-1:0];
    col_d   = c_n[COL_W-1:0];
    row_d   = r_n[ROW_W-1:0];
  end

  assign s1_adv     = s1_valid_q && (!s2_valid_q || item_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_emit    = (s1_row_q != '0) && (s1_col_q != '0);

  assign up1 = fwd_q ? fwd_data_q[PIX_W-1:0]     : rd_q[PIX_W-1:0];
  assign up2 = fwd_q ? fwd_data_q[MEM_W-1:PIX_W] : rd_q[MEM_W-1:PIX_W];

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_mem[s1_col_q] <= {up1, s1_pix_q};
    end
    if (accept) begin
      rd_q <= line_mem[cur_col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q   <= cur_col;
      s1_row_q   <= cur_row;
      s1_pix_q   <= pixel_i;
      fwd_q      <= s1_adv && (s1_col_q == cur_col);
      fwd_data_q <= {up1, s1_pix_q};
    end
    if (s1_adv) begin
      s2_row_q      <= s1_row_q - 1'b1;
      s2_col_q      <= s1_col_q - 1'b1;
      s2_interior_q <= (s1_row_q >= ROW_W'(2)) && (s1_col_q >= COL_W'(2));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_emit;
      end else if (item_ready_i) begin
        s2_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k][0] <= win_q[k][1];
          win_q[k][1] <= win_q[k][2];
        end
        win_q[0][2] <= up2;
        win_q[1][2] <= up1;
        win_q[2][2] <= s1_pix_q;
      end
    end
  end

  assign item_valid_o        = s2_valid_q;
  assign item_o.window       = win_q;
  assign item_o.interior     = s2_interior_q;
  assign item_o.centre_row   = s2_row_q;
  assign item_o.centre_col   = s2_col_q;

endmodule

// File: design/sobel_grad_pipe.sv
// ----------------------------------------------------------------------------
// sobel_grad_pipe
// Gradient arithmetic in three registered stages: derivatives, squares and
// their sum. The last stage is the output register.
// ----------------------------------------------------------------------------
module sobel_grad_pipe import sobel_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  win_item_t                item_i,
  input  logic                     item_valid_i,
  output logic                     item_ready_o,
  output logic signed [GRAD_W-1:0] grad_x_o,
  output logic signed [GRAD_W-1:0] grad_y_o,
  output logic [MAG_W-1:0]         grad_mag_sq_o,
  output logic [ROW_W-1:0]         centre_row_o,
  output logic [COL_W-1:0]         centre_col_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i
);

  logic signed [GRAD_W-1:0]   gx, gy;
  logic                       g1_valid_q, g2_valid_q, g3_valid_q;
  logic                       g1_ready, g2_ready;
  logic signed [GRAD_W-1:0]   g1_gx_q, g1_gy_q, g2_gx_q, g2_gy_q, g3_gx_q, g3_gy_q;
  logic [ROW_W-1:0]           g1_row_q, g2_row_q, g3_row_q;
  logic [COL_W-1:0]           g1_col_q, g2_col_q, g3_col_q;
  logic signed [2*GRAD_W-1:0] gx_w, gy_w, sq_x, sq_y;
  logic [SQ_W-1:0]            g2_sqx_q, g2_sqy_q;
  logic [MAG_W-1:0]           g3_mag_q;

  always_comb begin
    window_t w;
    w  = item_i.window;
    gx = (pix_ext(w[0][2]) - pix_ext(w[0][0]))
       + ((pix_ext(w[1][2]) - pix_ext(w[1][0])) <<< 1)
       + (pix_ext(w[2][2]) - pix_ext(w[2][0]));
    gy = (pix_ext(w[2][0]) - pix_ext(w[0][0]))
       + ((pix_ext(w[2][1]) - pix_ext(w[0][1])) <<< 1)
       + (pix_ext(w[2][2]) - pix_ext(w[0][2]));
    if (!item_i.interior) begin
      gx = '0;
      gy = '0;
    end
  end

  assign gx_w = (2*GRAD_W)'(g1_gx_q);
  assign gy_w = (2*GRAD_W)'(g1_gy_q);
  assign sq_x = gx_w * gx_w;
  assign sq_y = gy_w * gy_w;

  assign g2_ready     = !g3_valid_q || out_ready_i;
  assign g1_ready     = !g2_valid_q || g2_ready;
  assign item_ready_o = !g1_valid_q || g1_ready;

  always_ff @(posedge clk_i) begin
    if (item_valid_i && item_ready_o) begin
      g1_gx_q  <= gx;
      g1_gy_q  <= gy;
      g1_row_q <= item_i.centre_row;
      g1_col_q <= item_i.centre_col;
    end
    if (g1_valid_q && g1_ready) begin
      g2_sqx_q <= sq_x[SQ_W-1:0];
      g2_sqy_q <= sq_y[SQ_W-1:0];
      g2_gx_q  <= g1_gx_q;
      g2_gy_q  <= g1_gy_q;
      g2_row_q <= g1_row_q;
      g2_col_q <= g1_col_q;
    end
    if (g2_valid_q && g2_ready) begin
      g3_mag_q <= MAG_W'(g2_sqx_q) + MAG_W'(g2_sqy_q);
      g3_gx_q  <= g2_gx_q;
      g3_gy_q  <= g2_gy_q;
      g3_row_q <= g2_row_q;
      g3_col_q <= g2_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_valid_q <= 1'b0;
      g2_valid_q <= 1'b0;
      g3_valid_q <= 1'b0;
    end else begin
      if (item_ready_o) begin
        g1_valid_q <= item_valid_i;
      end
      if (g1_ready) begin
        g2_valid_q <= g1_valid_q;
      end
      if (g2_ready) begin
        g3_valid_q <= g2_valid_q;
      end
    end
  end

  assign out_valid_o   = g3_valid_q;
  assign grad_x_o      = g3_gx_q;
  assign grad_y_o      = g3_gy_q;
  assign grad_mag_sq_o = g3_mag_q;
  assign centre_row_o  = g3_row_q;
  assign centre_col_o  = g3_col_q;

endmodule

// File: sim/sobel_gradient_3x3_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_gradient_3x3_test
// Self-checking bench for the streaming 3x3 Sobel gradient block.
//
// Pixels are pushed through the valid/ready input with random gaps while the
// result side stalls at random. A scoreboard keeps its own line stores,
// window and position counters, works out the gradient beat that each pixel
// should cause and compares every result beat in order. Frame sizes are set
// over the register port between phases, including saturated values. The
// first forty columns of both line stores are filled before random traffic,
// and any wider frame starts afresh, so no result reads a stale entry.
// ----------------------------------------------------------------------------
module sobel_gradient_3x3_test import sobel_pkg::*; ();

  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 5000;
  localparam int PREFILL_COLS = 40;

  typedef struct {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [MAG_W-1:0]         mag;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
  } grad_t;

  class gradient_predictor;
    logic [PIX_W-1:0]  prev_row [MAX_COLS];
    logic [PIX_W-1:0]  older_row [MAX_COLS];
    int                win [3][3];
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [SIZE_W-1:0] cols_reg;
    logic [SIZE_W-1:0] rows_reg;
    grad_t             pending_grads [$];
    int                errors;

    function new();
      int i;
      for (i = 0; i < MAX_COLS; i++) begin
        prev_row[i] = '0;
        older_row[i] = '0;
      end
      for (i = 0; i < 9; i++) begin
        win[i / 3][i % 3] = 0;
      end
      row_pos = 0;
      col_pos = 0;
      cols_reg = COLS_RESET;
      rows_reg = ROWS_RESET;
      errors = 0;
    endfunction

    function int unsigned held_size(logic [SIZE_W-1:0] v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_size(logic [REG_IDX_W-1:0] idx, logic [SIZE_W-1:0] v);
      case (idx)
        REG_FRAME_COLS: cols_reg = v;
        REG_FRAME_ROWS: rows_reg = v;
        default: ;
      endcase
    endfunction

    function void take_pixel(logic [PIX_W-1:0] pix, logic fs);
      int unsigned ncols;
      int unsigned nrows;
      int unsigned r;
      int unsigned c;
      int          k;
      int          gx;
      int          gy;
      grad_t       g;
      ncols = held_size(cols_reg, MAX_COLS);
      nrows = held_size(rows_reg, MAX_ROWS);
      if (fs) begin
        row_pos = 0;
        col_pos = 0;
      end
      if (col_pos >= ncols) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= nrows) row_pos = 0;
      r = row_pos;
      c = col_pos;
      for (k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = older_row[c];
      win[1][2] = prev_row[c];
      win[2][2] = pix;
      older_row[c] = prev_row[c];
      prev_row[c] = pix;
      if (r >= 1 && c >= 1) begin
        gx = 0;
        gy = 0;
        if (r >= 2 && c >= 2) begin
          gx = (win[0][2] - win[0][0]) + 2 * (win[1][2] - win[1][0])
             + (win[2][2] - win[2][0]);
          gy = (win[2][0] - win[0][0]) + 2 * (win[2][1] - win[0][1])
             + (win[2][2] - win[0][2]);
        end
        g.gx = GRAD_W'(gx);
        g.gy = GRAD_W'(gy);
        g.mag = MAG_W'(gx * gx + gy * gy);
        g.row = ROW_W'(r - 1);
        g.col = COL_W'(c - 1);
        pending_grads.insert(pending_grads.size(), g);
      end
      col_pos = c + 1;
      if (col_pos >= ncols) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= nrows) row_pos = 0;
      end
    endfunction

    function void compare_field(string what, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_gradient(logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy,
                                 logic [MAG_W-1:0] mag, logic [ROW_W-1:0] row,
                                 logic [COL_W-1:0] col);
      grad_t g;
      if (pending_grads.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got row %0d col %0d",
                 $time, row, col);
        return;
      end
      g = pending_grads.pop_front();
      compare_field("grad_x", g.gx, gx);
      compare_field("grad_y", g.gy, gy);
      compare_field("grad_mag_sq", g.mag, mag);
      compare_field("centre_row", g.row, row);
      compare_field("centre_col", g.col, col);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic [PIX_W-1:0]         pixel_i;
  logic                     frame_start_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [GRAD_W-1:0] grad_x_o;
  logic signed [GRAD_W-1:0] grad_y_o;
  logic [MAG_W-1:0]         grad_mag_sq_o;
  logic [ROW_W-1:0]         centre_row_o;
  logic [COL_W-1:0]         centre_col_o;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0]    pwdata;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  gradient_predictor board = new();
  bit                no_gaps = 1'b0;
  int                quiet_cycles = 0;

  sobel_gradient_3x3 dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    if ($urandom_range(0, 9) < 3) return $urandom_range(0, 1) ? '1 : '0;
    return PIX_W'($urandom());
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(int hi);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return SIZE_W'($urandom_range(0, 2));
    if (roll == 1) return SIZE_W'($urandom_range(MAX_COLS + 1, 2047));
    return SIZE_W'($urandom_range(3, hi));
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pixel_i = pix;
    frame_start_i = fs;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_pixel(pix, fs);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (board.pending_grads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [REG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = ($urandom() & ~32'h7ff) | APB_DATA_W'(v);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_size(idx, v);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic run_random(input int target);
    int                sent;
    int                seg_len;
    int                k;
    bit                restart;
    logic [SIZE_W-1:0] cols_pick;
    sent = 0;
    while (sent < target) begin
      settle();
      cols_pick = pick_size(PREFILL_COLS);
      write_size(REG_FRAME_COLS, cols_pick);
      write_size(REG_FRAME_ROWS, pick_size(12));
      no_gaps = ($urandom_range(0, 3) == 0);
      seg_len = $urandom_range(20, 80);
      restart = ($urandom_range(0, 4) != 0) || (cols_pick > SIZE_W'(PREFILL_COLS));
      for (k = 0; k < seg_len; k++)
        send_pixel(pick_pixel(), (k == 0 && restart) || ($urandom_range(0, 99) == 0));
      sent += seg_len;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_ready_i = 1'b0;
      end else if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else begin
        out_ready_i = 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_gradient(grad_x_o, grad_y_o, grad_mag_sq_o, centre_row_o, centre_col_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("sobel_gradient_3x3_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    rst_ni = 1'b0;
    pixel_i = '0;
    frame_start_i = 1'b0;
    in_valid_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Sizes below the minimum are held to a 3 by 3 frame.
    write_size(REG_FRAME_COLS, SIZE_W'(0));
    write_size(REG_FRAME_ROWS, SIZE_W'(2));
    for (i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? '1 : '0, i == 0);
    for (i = 0; i < 9; i++) send_pixel((i < 3) ? '1 : '0, 1'b0);
    for (i = 0; i < 8; i++) send_pixel(PIX_W'(i * 341), i == 4);

    // Three rows of the widest narrow frame write every column it can reach.
    settle();
    write_size(REG_FRAME_COLS, SIZE_W'(PREFILL_COLS));
    write_size(REG_FRAME_ROWS, SIZE_W'(3));
    for (i = 0; i < 3 * PREFILL_COLS; i++) send_pixel(pick_pixel(), i == 0);

    run_random(450);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0 && board.pending_grads.size() == 0) begin
      $display("sobel_gradient_3x3_test: clean");
    end else begin
      $display("sobel_gradient_3x3_test: errors");
    end
    $finish;
  end

endmodule
